/* src/pol_pkg.sv */
// shared types and codes for the positional ordered list
package pol_pkg;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_PREPEND = 3'd1,
    OP_INSERT  = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_READ    = 3'd4,
    OP_SEARCH  = 3'd5,
    OP_CLEAR   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LEFT  = 2'd1,
    CELL_RIGHT = 2'd2,
    CELL_LOAD  = 2'd3
  } cell_mode_t;

endpackage

/* src/positional_ordered_list_top.sv */
// top level of the positional ordered list: command decode, cell row and result register
// the result is registered: it is valid in the cycle after the command transfer
// throughput: one command per cycle while results are taken; the cell row shifts, loads and compares in one step
// a result waiting in the output register is held until taken, input stalls only then
// reset clears the item count and the output valid; slot contents are left as they are
module positional_ordered_list_top #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [4:0]  position,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] data,
  output logic        found,
  output logic [3:0]  where_found,
  output logic [4:0]  count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = (CW > 5) ? CW : 5;

  logic [CW-1:0]        item_count;
  logic [CW-1:0]        item_count_next;
  logic                 accept;
  logic [WORD_BITS-1:0] key;
  logic [PW-1:0]        pos_w;
  logic [PW-1:0]        cnt_w;
  logic [PW-1:0]        ins_pos;
  logic                 is_put;
  logic                 do_ins;
  logic                 do_rem;
  pol_pkg::status_t     status_next;
  logic [WORD_BITS-1:0] read_word;
  logic                 hit;
  logic [IW-1:0]        hit_idx;

  logic [WORD_BITS-1:0] words [DEPTH];
  logic [DEPTH-1:0]     match_vec;
  pol_pkg::cell_mode_t  modes [DEPTH];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign key      = WORD_BITS'(value);
  assign pos_w    = PW'(position);
  assign cnt_w    = PW'(item_count);

  // command decode
  always_comb begin
    is_put          = 1'b0;
    ins_pos         = pos_w;
    do_ins          = 1'b0;
    do_rem          = 1'b0;
    status_next     = pol_pkg::ST_OK;
    item_count_next = item_count;
    case (pol_pkg::op_t'(op))
      pol_pkg::OP_APPEND: begin
        is_put  = 1'b1;
        ins_pos = cnt_w;
      end
      pol_pkg::OP_PREPEND: begin
        is_put  = 1'b1;
        ins_pos = '0;
      end
      pol_pkg::OP_INSERT: begin
        is_put = 1'b1;
      end
      pol_pkg::OP_REMOVE: begin
        if (pos_w >= cnt_w) begin
          status_next = pol_pkg::ST_RANGE;
        end else begin
          do_rem          = accept;
          item_count_next = item_count - CW'(1);
        end
      end
      pol_pkg::OP_READ: begin
        if (pos_w >= cnt_w) status_next = pol_pkg::ST_RANGE;
      end
      pol_pkg::OP_CLEAR: begin
        item_count_next = '0;
      end
      default: ;
    endcase
    if (is_put) begin
      if (ins_pos > cnt_w) begin
        status_next = pol_pkg::ST_RANGE;
      end else if (item_count == CW'(DEPTH)) begin
        status_next = pol_pkg::ST_FULL;
      end else begin
        do_ins          = accept;
        item_count_next = item_count + CW'(1);
      end
    end
  end

  // per-slot shift control
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      modes[i] = pol_pkg::CELL_HOLD;
      if (do_ins) begin
        if (PW'(i) == ins_pos) modes[i] = pol_pkg::CELL_LOAD;
        else if (PW'(i) > ins_pos) modes[i] = pol_pkg::CELL_LEFT;
      end else if (do_rem && PW'(i) >= pos_w) begin
        modes[i] = pol_pkg::CELL_RIGHT;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = key;
    end else begin : g_inner_l
      assign left_w = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = words[g];
    end else begin : g_inner_r
      assign right_w = words[g+1];
    end
    pol_cell #(.WORD_BITS(WORD_BITS)) u_cell (
      .clk        (clk),
      .mode       (modes[g]),
      .left_word  (left_w),
      .right_word (right_w),
      .load_word  (key),
      .key        (key),
      .word       (words[g]),
      .match      (match_vec[g])
    );
  end

  // read select and first-match search
  always_comb begin
    read_word = '0;
    hit       = 1'b0;
    hit_idx   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (PW'(i) == pos_w) read_word = read_word | words[i];
    end
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_vec[i] && PW'(i) < cnt_w) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        item_count <= item_count_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      count       <= 5'(item_count_next);
      data        <= (pol_pkg::op_t'(op) == pol_pkg::OP_READ && status_next == pol_pkg::ST_OK)
                     ? 32'(read_word) : '0;
      found       <= (pol_pkg::op_t'(op) == pol_pkg::OP_SEARCH) && hit;
      where_found <= (pol_pkg::op_t'(op) == pol_pkg::OP_SEARCH && hit) ? 4'(hit_idx) : '0;
    end
  end

endmodule

/* src/pol_cell.sv */
// one list slot: holds a word, shifts with its neighbors, compares against the search key
module pol_cell #(
  parameter int WORD_BITS = 32
) (
  input  logic                   clk,
  input  pol_pkg::cell_mode_t    mode,
  input  logic [WORD_BITS-1:0]   left_word,
  input  logic [WORD_BITS-1:0]   right_word,
  input  logic [WORD_BITS-1:0]   load_word,
  input  logic [WORD_BITS-1:0]   key,
  output logic [WORD_BITS-1:0]   word,
  output logic                   match
);

  always_ff @(posedge clk) begin
    unique case (mode)
      pol_pkg::CELL_HOLD:  word <= word;
      pol_pkg::CELL_LEFT:  word <= left_word;
      pol_pkg::CELL_RIGHT: word <= right_word;
      pol_pkg::CELL_LOAD:  word <= load_word;
      default:             word <= word;
    endcase
  end

  assign match = (word == key);

endmodule

/* tb/pol_checker.sv */
// checker for the positional ordered list: watches both channels, predicts and compares results
module pol_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  op,
  input  logic [4:0]  position,
  input  logic [31:0] value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [31:0] data,
  input  logic        found,
  input  logic [3:0]  where_found,
  input  logic [4:0]  count,
  output int          mismatches,
  output int          outstanding,
  output logic [4:0]  fill_level,
  output int          results_seen,
  output int          full_seen,
  output int          range_seen,
  output int          hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = 16;

  typedef struct {
    pol_pkg::status_t st;
    logic [31:0]      word;
    logic             hit;
    logic [3:0]       hit_idx;
    logic [4:0]       level;
  } list_result_t;

  logic [31:0]  slots [LIST_DEPTH];
  logic [4:0]   fill;
  list_result_t awaited[$];

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at %0t: got %0h, expected %0h", field, $time, got, want);
    mismatches++;
  endtask

  function automatic pol_pkg::status_t place_word(logic [4:0] pos, logic [31:0] w);
    if (pos > fill) return pol_pkg::ST_RANGE;
    if (fill >= LIST_DEPTH) return pol_pkg::ST_FULL;
    for (int i = LIST_DEPTH - 1; i > 0; i--)
      if (i > pos && i <= fill) slots[i] = slots[i - 1];
    slots[pos[3:0]] = w;
    fill++;
    return pol_pkg::ST_OK;
  endfunction

  function automatic list_result_t run_command(logic [2:0] c, logic [4:0] pos,
                                               logic [31:0] w);
    list_result_t r;
    r = '{pol_pkg::ST_OK, 32'd0, 1'b0, 4'd0, 5'd0};
    case (c)
      pol_pkg::OP_APPEND:  r.st = place_word(fill, w);
      pol_pkg::OP_PREPEND: r.st = place_word(5'd0, w);
      pol_pkg::OP_INSERT:  r.st = place_word(pos, w);
      pol_pkg::OP_REMOVE: begin
        if (pos >= fill) begin
          r.st = pol_pkg::ST_RANGE;
        end else begin
          for (int i = 0; i < LIST_DEPTH - 1; i++)
            if (i >= pos && i + 1 < fill) slots[i] = slots[i + 1];
          fill--;
        end
      end
      pol_pkg::OP_READ: begin
        if (pos >= fill) r.st = pol_pkg::ST_RANGE;
        else r.word = slots[pos[3:0]];
      end
      pol_pkg::OP_SEARCH: begin
        // scan from the back so the lowest match wins
        for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
          if (i < fill && slots[i] == w) begin
            r.hit = 1'b1;
            r.hit_idx = 4'(i);
          end
        end
      end
      pol_pkg::OP_CLEAR: fill = 5'd0;
      default: ;
    endcase
    r.level = fill;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    list_result_t want;
    if (rst) begin
      fill = 5'd0;
      awaited.delete();
      fill_level <= 5'd0;
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(count), 32'd0);
        end else begin
          want = awaited.pop_front();
          if (status != want.st) report_mismatch("status", 32'(status), 32'(want.st));
          if (data != want.word) report_mismatch("data", data, want.word);
          if (found != want.hit) report_mismatch("found", 32'(found), 32'(want.hit));
          if (where_found != want.hit_idx)
            report_mismatch("where_found", 32'(where_found), 32'(want.hit_idx));
          if (count != want.level) report_mismatch("count", 32'(count), 32'(want.level));
          if (want.st == pol_pkg::ST_FULL) full_seen++;
          if (want.st == pol_pkg::ST_RANGE) range_seen++;
          if (want.hit) hits_seen++;
        end
      end
      if (in_valid && in_ready) awaited.push_back(run_command(op, position, value));
      fill_level <= fill;
      outstanding <= awaited.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// testbench top for the positional ordered list: stimulus, flow control and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED   = 3'd7;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         CHUNK_ITEMS = 100;
  localparam int         CHUNKS      = 17;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  op;
  logic [4:0]  position;
  logic [31:0] value;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [31:0] data;
  logic        found;
  logic [3:0]  where_found;
  logic [4:0]  count;

  int          mismatches;
  int          outstanding;
  logic [4:0]  fill_level;
  int          results_seen;
  int          full_seen;
  int          range_seen;
  int          hits_seen;

  int          cycles = 0;
  int          sent = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  pol_pkg::op_t op_order [7] = '{pol_pkg::OP_APPEND, pol_pkg::OP_PREPEND, pol_pkg::OP_INSERT,
                                 pol_pkg::OP_REMOVE, pol_pkg::OP_READ, pol_pkg::OP_SEARCH,
                                 pol_pkg::OP_CLEAR};
  // cumulative op weights per mix: grow, shrink, balanced
  int          op_cut [3][7] = '{'{25, 40, 65, 72, 84, 97, 98},
                                 '{8, 14, 22, 60, 75, 92, 96},
                                 '{15, 25, 42, 62, 77, 93, 96}};
  logic [31:0] word_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                 32'h8000_0000, 32'h5A5A_5A5A, 32'h1234_5678};

  positional_ordered_list_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .position   (position),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .data       (data),
    .found      (found),
    .where_found(where_found),
    .count      (count)
  );

  pol_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .data        (data),
    .found       (found),
    .where_found (where_found),
    .count       (count),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .fill_level  (fill_level),
    .results_seen(results_seen),
    .full_seen   (full_seen),
    .range_seen  (range_seen),
    .hits_seen   (hits_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : result_sink
    int hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        hold = $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic issue(logic [2:0] c, logic [4:0] pos, logic [31:0] w);
    int gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= c;
    position <= pos;
    value <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain_list_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_command(int mix);
    logic [2:0]  c;
    logic [4:0]  pos;
    logic [31:0] w;
    int          roll;
    int          k;
    roll = $urandom_range(99);
    c = OP_UNUSED;
    for (k = 6; k >= 0; k--)
      if (roll < op_cut[mix][k]) c = op_order[k];
    if ($urandom_range(99) < 85) pos = 5'($urandom_range(0, fill_level));
    else pos = 5'($urandom_range(0, 31));
    if ($urandom_range(99) < 40) w = word_pool[$urandom_range(0, 5)];
    else w = $urandom();
    issue(c, pos, w);
  endtask

  initial begin : stimulus
    int pcts [4];
    pcts = '{0, 10, 30, 60};
    rst = 1'b1;
    in_valid = 1'b0;
    op = pol_pkg::OP_APPEND;
    position = 5'd0;
    value = 32'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty list corner cases
    issue(pol_pkg::OP_READ, 5'd0, 32'd0);
    issue(pol_pkg::OP_REMOVE, 5'd0, 32'd0);
    issue(pol_pkg::OP_SEARCH, 5'd0, 32'd0);
    issue(OP_UNUSED, 5'd31, 32'hFFFF_FFFF);
    issue(pol_pkg::OP_INSERT, 5'd1, 32'h1111_1111);
    issue(pol_pkg::OP_INSERT, 5'd0, 32'h1234_5678);
    issue(pol_pkg::OP_APPEND, 5'd0, 32'h0000_0000);
    issue(pol_pkg::OP_APPEND, 5'd0, 32'hFFFF_FFFF);
    issue(pol_pkg::OP_PREPEND, 5'd0, 32'hA5A5_A5A5);
    issue(pol_pkg::OP_INSERT, 5'd2, 32'h0000_FFFF);
    issue(pol_pkg::OP_INSERT, 5'd5, 32'hFFFF_0000);
    issue(pol_pkg::OP_INSERT, 5'd7, 32'h2222_2222);
    issue(pol_pkg::OP_INSERT, 5'd31, 32'h3333_3333);
    issue(pol_pkg::OP_READ, 5'd0, 32'd0);
    issue(pol_pkg::OP_READ, 5'd5, 32'd0);
    issue(pol_pkg::OP_READ, 5'd6, 32'd0);
    issue(pol_pkg::OP_READ, 5'd31, 32'd0);
    issue(pol_pkg::OP_SEARCH, 5'd0, 32'hFFFF_FFFF);
    issue(pol_pkg::OP_SEARCH, 5'd0, 32'hDEAD_BEEF);
    issue(pol_pkg::OP_REMOVE, 5'd2, 32'd0);
    issue(pol_pkg::OP_REMOVE, 5'd0, 32'd0);
    issue(pol_pkg::OP_REMOVE, 5'd31, 32'd0);
    issue(pol_pkg::OP_CLEAR, 5'd0, 32'd0);
    // removing the only word
    issue(pol_pkg::OP_APPEND, 5'd0, 32'h0000_0007);
    issue(pol_pkg::OP_REMOVE, 5'd0, 32'd0);
    issue(pol_pkg::OP_SEARCH, 5'd0, 32'h0000_0007);
    drain_list_results();

    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      if (chunk >= CHUNKS - 2) begin
        idle_pct = 0;
        stall_pct = 0;
      end else begin
        idle_pct = pcts[$urandom_range(0, 3)];
        stall_pct = pcts[$urandom_range(0, 3)];
      end
      for (int n = 0; n < CHUNK_ITEMS; n++) random_command(chunk % 3);
      if (chunk % 4 == 3) drain_list_results();
    end

    drain_list_results();
    repeat (4) @(posedge clk);
    $display("%0d commands sent, %0d results checked", sent, results_seen);
    $display("%0d full, %0d out of range, %0d search hits", full_seen, range_seen, hits_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* positional_ordered_list_top.f */
src/pol_pkg.sv
src/pol_cell.sv
src/positional_ordered_list_top.sv
tb/pol_checker.sv
tb/tb_top.sv
